// File: src/psq_pkg.sv
// Shared constants, widths and codes for the pitch scale quantizer.
package psq_pkg;

    // Payload widths
    localparam int ACTION_W = 1;
    localparam int INDEX_W  = 7;
    localparam int VALUE_W  = 16;
    localparam int PITCH_W  = 15;
    localparam int TUNE_W   = 12;
    localparam int COUNT_W  = 8;
    localparam int OFFSET_W = 17;
    localparam int WRAP_W   = 18;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUANTIZE_ENABLE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT     = 1'd1;

    localparam logic               QUANTIZE_ENABLE_RST = 1'b1;
    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST     = 8'd120;

    // Item actions
    localparam logic [ACTION_W-1:0] ACT_LOAD     = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_QUANTIZE = 1'b1;

    // Q8 semitone constants
    localparam logic signed [WRAP_W-1:0] OCTAVE_Q8 = 18'sd3072;
    localparam logic signed [WRAP_W-1:0] TOP_Q8    = 18'sd30720;
    localparam logic [PITCH_W-1:0]       TONIC_MAX = 15'd30720;
    localparam logic [12:0]              TUNE_FULL = 13'd4095;

    localparam int DEFAULT_TABLE_DEPTH = 128;

endpackage

// File: src/psq_if.sv
// Valid/ready channel interfaces for quantizer items and results.
interface psq_in_if import psq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [INDEX_W-1:0]         table_index;
    logic signed [VALUE_W-1:0]  table_value;
    logic [PITCH_W-1:0]         pitch;
    logic [TUNE_W-1:0]          tune;

    modport source (output valid, action, table_index, table_value, pitch, tune,
                    input ready);
    modport sink   (input valid, action, table_index, table_value, pitch, tune,
                    output ready);
endinterface

interface psq_out_if import psq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PITCH_W-1:0] pitch_out;

    modport source (output valid, pitch_out, input ready);
    modport sink   (input valid, pitch_out, output ready);
endinterface

// File: src/psq_scale_ram.sv
// Scale table memory: one write port, one registered read port.
module psq_scale_ram import psq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic signed [VALUE_W-1:0]  wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic signed [VALUE_W-1:0]  rd_data
);

    logic signed [VALUE_W-1:0] table_mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/pitch_scale_quantizer_unit.sv
// Pitch scale quantizer top level: sequencer, tonic, binary search, octave wrap.
// Load beat: table write only, no result. Bypass beat: pitch goes straight to S_DONE.
// Quantize beat: tonic, offset, end checks, binary search, add tonic, octave wrap;
// one table read per search step sets the pace.
// Input is held off from accept until the result moves to the output register.
// Reset: async active low; config back to enable=1, entry_count=120; table not cleared.
module pitch_scale_quantizer_unit import psq_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    psq_in_if.sink                 in_ch,
    psq_out_if.source              out_ch
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;   // waiting for a beat
    localparam logic [3:0] S_TONIC = 4'd1;   // tonic from tune
    localparam logic [3:0] S_OFFS  = 4'd2;   // offset = pitch - tonic, read entry 0
    localparam logic [3:0] S_CHK0  = 4'd3;   // below first entry? read last entry
    localparam logic [3:0] S_CHKN  = 4'd4;   // above last entry?
    localparam logic [3:0] S_MID   = 4'd5;   // pick midpoint, read it
    localparam logic [3:0] S_CMID  = 4'd6;   // compare midpoint, read neighbor
    localparam logic [3:0] S_CNB   = 4'd7;   // compare neighbor
    localparam logic [3:0] S_ADD   = 4'd8;   // add tonic back
    localparam logic [3:0] S_WRAP  = 4'd9;   // one octave step per cycle
    localparam logic [3:0] S_DONE  = 4'd10;  // hand result to output register

    // Control registers
    logic [3:0]         state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic               quant_en_reg;
    logic [COUNT_W-1:0] entry_count_reg;

    // Datapath registers
    logic [PITCH_W-1:0]         pitch_reg, pitch_next;
    logic [TUNE_W-1:0]          tune_reg, tune_next;
    logic [PITCH_W-1:0]         tonic_reg, tonic_next;
    logic signed [OFFSET_W-1:0] offs_reg, offs_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [AW-1:0]              mid_reg, mid_next;
    logic                       dir_low_reg, dir_low_next;
    logic signed [VALUE_W-1:0]  emid_reg, emid_next;
    logic signed [VALUE_W-1:0]  res_reg, res_next;
    logic signed [WRAP_W-1:0]   wrap_reg, wrap_next;
    logic                       bypass_reg, bypass_next;
    logic [PITCH_W-1:0]         out_pitch_reg;

    // Memory port
    logic                      ram_we;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    logic signed [OFFSET_W-1:0] rd_ext;

    // Misc combinational
    logic               in_fire;
    logic               out_load;
    logic [CW-1:0]      n_eff;
    logic [CW:0]        lohi_sum;
    logic [AW-1:0]      mid_calc;
    logic [15:0]        tune_x15;
    logic [14:0]        tn_a;
    logic [15:0]        tn_s;
    logic [12:0]        tn_t;

    // Nearer of two entries around t; ties go to the upper one.
    function automatic logic signed [VALUE_W-1:0] nearer(
        input logic signed [VALUE_W-1:0]  lo_e,
        input logic signed [VALUE_W-1:0]  hi_e,
        input logic signed [OFFSET_W-1:0] t
    );
        logic signed [OFFSET_W:0] d_lo;
        logic signed [OFFSET_W:0] d_hi;
        d_lo = $signed({t[OFFSET_W-1], t}) - $signed({{2{lo_e[VALUE_W-1]}}, lo_e});
        d_hi = $signed({{2{hi_e[VALUE_W-1]}}, hi_e}) - $signed({t[OFFSET_W-1], t});
        nearer = (d_lo >= d_hi) ? hi_e : lo_e;
    endfunction

    assign in_fire      = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.pitch_out = out_pitch_reg;

    assign ram_we = in_fire && (in_ch.action == ACT_LOAD)
                    && (32'(in_ch.table_index) < TABLE_DEPTH);
    assign rd_ext = $signed({rd_data[VALUE_W-1], rd_data});

    // Effective entry count: zero acts as one, saturate at depth
    always_comb
    begin
        if (entry_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(entry_count_reg) > TABLE_DEPTH)
        begin
            n_eff = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = CW'(entry_count_reg);
        end
    end

    assign lohi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = AW'(lohi_sum >> 1);

    // Tonic = floor(30720*tune/4095). 30720*tune = (15*tune) << 11; fold the
    // 4096 digits twice (4096 = 4095 + 1), then one final compare.
    assign tune_x15 = ({4'b0, tune_reg} << 4) - {4'b0, tune_reg};
    assign tn_a     = tune_x15[15:1];
    assign tn_s     = {1'b0, tn_a} + {4'b0, tune_x15[0], 11'b0};
    assign tn_t     = {9'b0, tn_s[15:12]} + {1'b0, tn_s[11:0]};

    psq_scale_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_scale_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (AW'(in_ch.table_index)),
        .wr_data (in_ch.table_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        pitch_next   = pitch_reg;
        tune_next    = tune_reg;
        tonic_next   = tonic_reg;
        offs_next    = offs_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        dir_low_next = dir_low_reg;
        emid_next    = emid_reg;
        res_next     = res_reg;
        wrap_next    = wrap_reg;
        bypass_next  = bypass_reg;
        rd_addr      = '0;
        out_load     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_ch.action == ACT_QUANTIZE))
                begin
                    if (!quant_en_reg)
                    begin
                        wrap_next   = $signed({3'b0, in_ch.pitch});
                        bypass_next = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        pitch_next  = in_ch.pitch;
                        tune_next   = in_ch.tune;
                        bypass_next = 1'b0;
                        state_next  = S_TONIC;
                    end
                end
            end

            S_TONIC:
            begin
                tonic_next = tn_a + PITCH_W'(tn_s[15:12])
                             + PITCH_W'(tn_t >= TUNE_FULL);
                state_next = S_OFFS;
            end

            S_OFFS:
            begin
                offs_next  = $signed({2'b0, pitch_reg}) - $signed({2'b0, tonic_reg});
                rd_addr    = '0;
                state_next = S_CHK0;
            end

            S_CHK0:
            begin
                rd_addr = AW'(n_eff - CW'(1));
                if (offs_reg <= rd_ext)
                begin
                    res_next   = rd_data;
                    state_next = S_ADD;
                end
                else
                begin
                    state_next = S_CHKN;
                end
            end

            S_CHKN:
            begin
                if (offs_reg >= rd_ext)
                begin
                    res_next   = rd_data;
                    state_next = S_ADD;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = n_eff;
                    state_next = S_MID;
                end
            end

            S_MID:
            begin
                rd_addr = mid_calc;
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = S_CMID;
                end
                else
                begin
                    // search ran out: last midpoint read wins
                    res_next   = emid_reg;
                    state_next = S_ADD;
                end
            end

            S_CMID:
            begin
                emid_next = rd_data;
                rd_addr   = (offs_reg < rd_ext) ? (mid_reg - AW'(1)) : (mid_reg + AW'(1));
                if (offs_reg == rd_ext)
                begin
                    res_next   = rd_data;
                    state_next = S_ADD;
                end
                else if (offs_reg < rd_ext)
                begin
                    if (mid_reg != '0)
                    begin
                        dir_low_next = 1'b1;
                        state_next   = S_CNB;
                    end
                    else
                    begin
                        hi_next    = CW'(mid_reg);
                        state_next = S_MID;
                    end
                end
                else
                begin
                    if ((CW'(mid_reg) + CW'(1)) < n_eff)
                    begin
                        dir_low_next = 1'b0;
                        state_next   = S_CNB;
                    end
                    else
                    begin
                        lo_next    = CW'(mid_reg) + CW'(1);
                        state_next = S_MID;
                    end
                end
            end

            S_CNB:
            begin
                if (dir_low_reg)
                begin
                    if (offs_reg > rd_ext)
                    begin
                        res_next   = nearer(rd_data, emid_reg, offs_reg);
                        state_next = S_ADD;
                    end
                    else
                    begin
                        hi_next    = CW'(mid_reg);
                        state_next = S_MID;
                    end
                end
                else
                begin
                    if (offs_reg < rd_ext)
                    begin
                        res_next   = nearer(emid_reg, rd_data, offs_reg);
                        state_next = S_ADD;
                    end
                    else
                    begin
                        lo_next    = CW'(mid_reg) + CW'(1);
                        state_next = S_MID;
                    end
                end
            end

            S_ADD:
            begin
                wrap_next  = $signed({3'b0, tonic_reg})
                             + $signed({{2{res_reg[VALUE_W-1]}}, res_reg});
                state_next = S_WRAP;
            end

            S_WRAP:
            begin
                if (wrap_reg < 0)
                begin
                    wrap_next = wrap_reg + OCTAVE_Q8;
                end
                else if (wrap_reg > TOP_Q8)
                begin
                    wrap_next = wrap_reg - OCTAVE_Q8;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ch.ready);

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            quant_en_reg    <= QUANTIZE_ENABLE_RST;
            entry_count_reg <= ENTRY_COUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_QUANTIZE_ENABLE: quant_en_reg    <= cfg_wdata[0];
                    CFG_ENTRY_COUNT:     entry_count_reg <= cfg_wdata;
                    default:             ;
                endcase
            end
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge clk)
    begin
        pitch_reg   <= pitch_next;
        tune_reg    <= tune_next;
        tonic_reg   <= tonic_next;
        offs_reg    <= offs_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        dir_low_reg <= dir_low_next;
        emid_reg    <= emid_next;
        res_reg     <= res_next;
        wrap_reg    <= wrap_next;
        bypass_reg  <= bypass_next;
        if (out_load)
        begin
            out_pitch_reg <= wrap_reg[PITCH_W-1:0];
        end
    end

`ifndef SYNTHESIS
    // search window stays inside the valid entries
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MID) |-> (lo_reg <= hi_reg) && (hi_reg <= n_eff))
        else $error("search window out of range");

    // a quantized result is in 0..120 semitones when handed off
    a_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !bypass_reg) |-> (wrap_reg >= 0) && (wrap_reg <= TOP_Q8))
        else $error("quantized pitch outside 0..120");

    // tonic never exceeds 120 semitones
    a_tonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OFFS) |-> (tonic_reg <= TONIC_MAX))
        else $error("tonic out of range");

    // table loads finish in the accepting cycle
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_ch.action == ACT_LOAD) |=> (state_reg == S_IDLE))
        else $error("load beat left sequencer busy");

    // quantize beats with the scale on start the tonic step
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_ch.action == ACT_QUANTIZE && quant_en_reg) |=> (state_reg == S_TONIC))
        else $error("quantize beat did not start search");
`endif

endmodule

// File: bench/tb.sv
// Testbench for the pitch scale quantizer: table loads and quantize beats against a scoreboard.
`timescale 1ns / 100ps

module tb;
    import psq_pkg::*;

    localparam int DEPTH        = DEFAULT_TABLE_DEPTH;
    // A load can still be in flight when the last result has come, so wait
    // this long before a config write.
    localparam int IDLE_WAIT    = 64;
    localparam int RANDOM_BEATS = 850;
    localparam int LONG_HOLD    = 300;   // receiver hold-off that backs the block up

    typedef struct {
        logic [ACTION_W-1:0]       action;
        logic [INDEX_W-1:0]        table_index;
        logic signed [VALUE_W-1:0] table_value;
        logic [PITCH_W-1:0]        pitch;
        logic [TUNE_W-1:0]         tune;
    } psq_beat_t;

    // Receiver stall patterns
    typedef enum int {SINK_FREE, SINK_STEADY, SINK_COIN, SINK_SLOW} sink_mode_t;

    // Tracks the scale table and registers, predicts each quantized pitch
    // and checks results in order.
    class pitch_scoreboard;
        logic signed [OFFSET_W-1:0] scale_notes [DEPTH];
        logic                       quantize_on;
        logic [COUNT_W-1:0]         entry_count;
        logic [PITCH_W-1:0]         pending_pitches [$];
        int                         mismatches;

        function new();
            foreach (scale_notes[k])
                scale_notes[k] = '0;
            quantize_on = QUANTIZE_ENABLE_RST;
            entry_count = ENTRY_COUNT_RST;
            mismatches  = 0;
        endfunction

        function int note_at(int k);
            return int'(scale_notes[k]);
        endfunction

        // Q8 tonic: 120 semitones full scale over a 12-bit reading, truncated
        function int tonic_of(logic [TUNE_W-1:0] tune);
            return (int'(TONIC_MAX) * int'(tune)) / int'(TUNE_FULL);
        endfunction

        // Tie goes to the upper note
        function int pick_nearer(int lower, int upper, int target);
            if (target - lower >= upper - target)
                return upper;
            return lower;
        endfunction

        function int nearest_note(int target);
            int n;
            int lo;
            int hi;
            int mid;
            n = entry_count;
            if (n == 0)
                n = 1;
            if (n > DEPTH)
                n = DEPTH;
            if (target <= note_at(0))
                return note_at(0);
            if (target >= note_at(n - 1))
                return note_at(n - 1);
            lo  = 0;
            hi  = n;
            mid = 0;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (note_at(mid) == target)
                    return note_at(mid);
                if (target < note_at(mid))
                begin
                    if (mid > 0 && target > note_at(mid - 1))
                        return pick_nearer(note_at(mid - 1), note_at(mid), target);
                    hi = mid;
                end
                else
                begin
                    if (mid < n - 1 && target < note_at(mid + 1))
                        return pick_nearer(note_at(mid), note_at(mid + 1), target);
                    lo = mid + 1;
                end
            end
            return note_at(mid);
        endfunction

        function logic [PITCH_W-1:0] quantize_pitch(logic [PITCH_W-1:0] pitch,
                                                    logic [TUNE_W-1:0] tune);
            int tonic;
            int landed;
            if (!quantize_on)
                return pitch;
            tonic  = tonic_of(tune);
            landed = tonic + nearest_note(int'(pitch) - tonic);
            while (landed < 0)
                landed += int'(OCTAVE_Q8);
            while (landed > int'(TOP_Q8))
                landed -= int'(OCTAVE_Q8);
            return landed[PITCH_W-1:0];
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_QUANTIZE_ENABLE: quantize_on = data[0];
                CFG_ENTRY_COUNT:     entry_count = data[COUNT_W-1:0];
                default:             ;
            endcase
        endfunction

        function void note_beat(psq_beat_t b);
            if (b.action == ACT_LOAD)
                scale_notes[b.table_index] = OFFSET_W'(b.table_value);
            else
                pending_pitches.push_back(quantize_pitch(b.pitch, b.tune));
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic [PITCH_W-1:0] got);
            logic [PITCH_W-1:0] want;
            if (pending_pitches.size() == 0)
            begin
                report($sformatf("pitch_out %0d with no quantize beat pending", got));
                return;
            end
            want = pending_pitches.pop_front();
            if (got !== want)
                report($sformatf("pitch_out %0d, expected %0d", got, want));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    psq_in_if  in_ch();
    psq_out_if out_ch();

    pitch_scale_quantizer_unit #(.TABLE_DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    pitch_scoreboard sb;
    int              burst_left    = 8;   // beats left in the current sender burst
    int              hold_requests = 0;   // bumped by the sender, served by the receiver

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Offer one beat, hold it until accepted, then maybe open a gap.
    // valid only drops when a gap follows, so it never toggles twice in a step.
    task automatic push_beat(psq_beat_t b);
        in_ch.valid       <= 1'b1;
        in_ch.action      <= b.action;
        in_ch.table_index <= b.table_index;
        in_ch.table_value <= b.table_value;
        in_ch.pitch       <= b.pitch;
        in_ch.tune        <= b.tune;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_beat(b);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 5))
                @(posedge clk);
            // Mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Unused payload fields carry random bits
    task automatic send_load(int idx, int value);
        psq_beat_t b;
        b.action      = ACT_LOAD;
        b.table_index = INDEX_W'(idx);
        b.table_value = VALUE_W'(value);
        b.pitch       = PITCH_W'($urandom);
        b.tune        = TUNE_W'($urandom);
        push_beat(b);
    endtask

    task automatic send_quantize(int pitch, int tune);
        psq_beat_t b;
        b.action      = ACT_QUANTIZE;
        b.table_index = INDEX_W'($urandom);
        b.table_value = VALUE_W'($urandom);
        b.pitch       = PITCH_W'(pitch);
        b.tune        = TUNE_W'(tune);
        push_beat(b);
    endtask

    // Drain: all results in, then let a trailing load finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending_pitches.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT)
            @(posedge clk);
    endtask

    // Extra edge after the write keeps back-to-back writes from stacking
    // two assignments to cfg_we in one step.
    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.set_register(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: checks each result beat and stalls on its own pattern.
    // A long hold-off, when requested, is counted here.
    initial
    begin
        sink_mode_t mode;
        int         mode_left;
        int         hold_left;
        int         holds_served;
        mode         = SINK_FREE;
        mode_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_result(out_ch.pitch_out);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode      = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_FREE:   out_ch.ready <= 1'b1;
                    SINK_STEADY: out_ch.ready <= (mode_left % 4 != 0);
                    SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                    default:     out_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Stimulus
    initial
    begin
        int               phase;
        int               count_cfg;
        int               n_eff;
        int               v;
        int               step;
        int               step_max;
        int               k;
        int               target;
        int               quant_beats;
        int               random_sent;
        bit               quant_on;
        bit               on_grid;
        logic [TUNE_W-1:0] tn;

        sb = new();
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_wdata         <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_LOAD;
        in_ch.table_index <= '0;
        in_ch.table_value <= '0;
        in_ch.pitch       <= '0;
        in_ch.tune        <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed ----
        // Entry count zero acts as one entry: only entry 0 is read.
        write_register(CFG_ENTRY_COUNT, CFG_DATA_W'(0));
        send_load(0, 0);
        send_quantize(0, 0);
        send_quantize(32767, 4095);         // pitch above 120, full tune
        send_quantize(30720, 2048);
        send_load(0, -32768);               // most negative offset: wraps up
        send_quantize(0, 0);
        send_load(0, 32767);                // most positive offset: wraps down
        send_quantize(0, 4095);

        // Four-note scale: exact hit, tie, below first, above last, between
        settle();
        write_register(CFG_ENTRY_COUNT, CFG_DATA_W'(4));
        send_load(0, -768);
        send_load(1, 0);
        send_load(2, 512);
        send_load(3, 1024);
        send_quantize(512, 0);
        send_quantize(256, 0);
        send_quantize(0, 4095);
        send_quantize(30000, 0);
        send_quantize(700, 0);
        send_load(2, -2000);                // table no longer ascending
        send_quantize(300, 0);

        // Bypass passes pitch straight through
        settle();
        write_register(CFG_QUANTIZE_ENABLE, CFG_DATA_W'(0));
        send_quantize(32767, 0);
        send_quantize(0, 4095);
        settle();
        write_register(CFG_QUANTIZE_ENABLE, CFG_DATA_W'(1));

        // ---- Random phases: config, fresh ascending scale, quantize stream ----
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_BEATS)
        begin
            // First phases hit the count extremes, then mostly small scales
            case (phase)
                0:       count_cfg = DEPTH;
                1:       count_cfg = 255;
                2:       count_cfg = 1;
                default:
                begin
                    k = $urandom_range(0, 9);
                    if (k == 0)
                        count_cfg = 0;
                    else if (k == 1)
                        count_cfg = $urandom_range(100, 255);
                    else
                        count_cfg = $urandom_range(1, 16);
                end
            endcase
            quant_on = (phase < 3) ? 1'b1 : ($urandom_range(0, 6) != 0);
            n_eff    = (count_cfg == 0) ? 1 : ((count_cfg > DEPTH) ? DEPTH : count_cfg);

            settle();
            write_register(CFG_QUANTIZE_ENABLE, CFG_DATA_W'(quant_on));
            write_register(CFG_ENTRY_COUNT, CFG_DATA_W'(count_cfg));

            // Every entry the search may touch is written before any quantize.
            // Steps are bounded so the scale stays ascending inside 16 bits;
            // a grid scale on whole semitones makes exact hits and ties common.
            on_grid = ($urandom_range(0, 2) == 0);
            v       = on_grid ? -256 * int'($urandom_range(0, 127))
                              : -int'($urandom_range(0, 32768));
            for (k = 0; k < n_eff; k++)
            begin
                send_load(k, v);
                random_sent++;
                step_max = (32767 - v) / (n_eff - k);
                if (on_grid && step_max >= 256)
                    step = 256 * int'($urandom_range(1, step_max / 256));
                else
                    step = $urandom_range(1, step_max);
                v += step;
            end

            // Back the output up while the sender keeps offering
            if (phase == 3 || phase == 7)
            begin
                hold_requests <= hold_requests + 1;
                quant_beats = 50;
            end
            else
                quant_beats = $urandom_range(15, 50);

            repeat (quant_beats)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    // Stray load: any entry, any value, may break the ordering
                    send_load($urandom_range(0, DEPTH - 1), $urandom_range(0, 65535));
                end
                else
                begin
                    tn = TUNE_W'($urandom_range(0, 4095));
                    if ($urandom_range(0, 9) == 0)
                        tn = $urandom_range(0, 1) ? TUNE_W'(4095) : TUNE_W'(0);
                    k = $urandom_range(0, 9);
                    if (k < 3)
                    begin
                        // Aim at a note, just off it, or midway to the next one
                        k      = $urandom_range(0, n_eff - 1);
                        target = sb.tonic_of(tn) + sb.note_at(k);
                        case ($urandom_range(0, 2))
                            1: target += int'($urandom_range(0, 2)) - 1;
                            2: if (k < n_eff - 1)
                                   target = sb.tonic_of(tn)
                                            + (sb.note_at(k) + sb.note_at(k + 1)) / 2;
                            default: ;
                        endcase
                        if (target < 0 || target > 32767)
                            target = $urandom_range(0, 30720);
                    end
                    else if (k == 3)
                        target = $urandom_range(0, 32767);
                    else
                        target = $urandom_range(0, 30720);
                    send_quantize(target, tn);
                end
                random_sent++;
            end
            phase++;
        end

        settle();
        if (sb.pending_pitches.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_pitches.size()));
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
src/psq_pkg.sv
src/psq_if.sv
src/psq_scale_ram.sv
src/pitch_scale_quantizer_unit.sv
bench/tb.sv
